// ----- rtl/nnis_pkg.sv -----
// ----------------------------------------------------------------------------
// nnis_pkg
// Shared constants, command codes and register indexes for the scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package nnis_pkg;

    localparam int PIX_W      = 32;
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_CRD_W  = 10;

    localparam int DEF_MAX_PIXELS = 16384;
    localparam int DEF_MAX_DIM    = 1024;

    localparam int RST_SRC_WIDTH  = 128;
    localparam int RST_SRC_HEIGHT = 128;
    localparam int RST_DST_WIDTH  = 82;
    localparam int RST_DST_HEIGHT = 52;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } cfg_idx_t;

endpackage

`default_nettype wire

// ----- rtl/nnis_in_if.sv -----
// ----------------------------------------------------------------------------
// nnis_in_if
// Request channel into the scaler: command and source pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnis_in_if;
    import nnis_pkg::*;

    logic             valid;
    logic             ready;
    logic             cmd;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output cmd, output pixel_in, input ready);
    modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/nnis_out_if.sv -----
// ----------------------------------------------------------------------------
// nnis_out_if
// Result channel out of the scaler: destination pixel and its position.
// ----------------------------------------------------------------------------
`default_nettype none

interface nnis_out_if;
    import nnis_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     pixel_out;
    logic [OUT_CRD_W-1:0] dest_x;
    logic [OUT_CRD_W-1:0] dest_y;
    logic                 last_of_frame;

    modport source (output valid, output pixel_out, output dest_x, output dest_y,
                    output last_of_frame, input ready);
    modport sink   (input valid, input pixel_out, input dest_x, input dest_y,
                    input last_of_frame, output ready);
endinterface

`default_nettype wire

// ----- rtl/nearest_neighbor_image_scaler.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Loads source pixels into a frame store and emits the destination frame by
// nearest neighbor, stepping source column/row with remainder accumulators.
// Load: accepted every cycle while idle and not settling, written in the accept cycle.
// Emit: address multiply, store read, then output stage, which waits for a free
//   output register; no new request is taken until the emit is through.
// First emit after reset or a register write: plus 4 divisions to rebuild the
//   steppers.
// A register write holds off requests in the cycle after it. Reset clears control
//   and position state; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_neighbor_image_scaler #(
    parameter int MAX_PIXELS = nnis_pkg::DEF_MAX_PIXELS,
    parameter int MAX_DIM    = nnis_pkg::DEF_MAX_DIM
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    nnis_in_if.sink                            in_ch,
    nnis_out_if.source                         out_ch,
    input  wire logic                          cfg_we,
    input  wire logic [nnis_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [nnis_pkg::CFG_W-1:0]    cfg_data
);
    import nnis_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CRD_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int SUM_W  = DIM_W + 1;
    localparam int POS_W  = 2 * DIM_W;
    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    localparam int RST_SW = (RST_SRC_WIDTH  > MAX_DIM) ? MAX_DIM : RST_SRC_WIDTH;
    localparam int RST_SH = (RST_SRC_HEIGHT > MAX_DIM) ? MAX_DIM : RST_SRC_HEIGHT;
    localparam int RST_DW = (RST_DST_WIDTH  > MAX_DIM) ? MAX_DIM : RST_DST_WIDTH;
    localparam int RST_DH = (RST_DST_HEIGHT > MAX_DIM) ? MAX_DIM : RST_DST_HEIGHT;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_DIV,
        S_EMIT,
        S_RD,
        S_DATA
    } state_t;

    typedef enum logic [1:0] {
        OP_COL,
        OP_ROW,
        OP_CSTEP,
        OP_RSTEP
    } div_op_t;

    state_t  state_reg, state_next;
    div_op_t op_reg, op_next;

    // effective dimensions, already clamped to 1..MAX_DIM
    logic [DIM_W-1:0] sw_reg, sw_next;
    logic [DIM_W-1:0] sh_reg, sh_next;
    logic [DIM_W-1:0] dw_reg, dw_next;
    logic [DIM_W-1:0] dh_reg, dh_next;
    logic [POS_W-1:0] total_reg, total_next;
    logic             settle_reg, settle_next;
    logic             geom_ok_reg, geom_ok_next;

    logic [POS_W-1:0] wp_reg, wp_next;

    logic [CRD_W-1:0] col_reg, col_next;
    logic [CRD_W-1:0] row_reg, row_next;
    logic [CRD_W-1:0] cq_reg, cq_next;
    logic [DIM_W-1:0] cr_reg, cr_next;
    logic [CRD_W-1:0] rq_reg, rq_next;
    logic [DIM_W-1:0] rr_reg, rr_next;
    logic [DIM_W-1:0] csq_reg, csq_next;
    logic [DIM_W-1:0] csr_reg, csr_next;
    logic [DIM_W-1:0] rsq_reg, rsq_next;
    logic [DIM_W-1:0] rsr_reg, rsr_next;

    logic             div_start_reg, div_start_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             pend_in_reg, pend_in_next;
    logic [OUT_CRD_W-1:0] pend_x_reg, pend_x_next;
    logic [OUT_CRD_W-1:0] pend_y_reg, pend_y_next;
    logic             pend_last_reg, pend_last_next;

    logic                 out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]     out_pix_reg, out_pix_next;
    logic [OUT_CRD_W-1:0] out_x_reg, out_x_next;
    logic [OUT_CRD_W-1:0] out_y_reg, out_y_next;
    logic                 out_last_reg, out_last_next;

    // combinational helpers
    logic             in_ready;
    logic             in_acc;
    logic [31:0]      cfg_val;
    logic [DIM_W-1:0] cfg_dim;
    logic [POS_W-1:0] wp_eff;
    logic [POS_W-1:0] wp_inc;
    logic             wp_in_store;
    logic [SUM_W-1:0] row_t;
    logic             col_last;
    logic             row_last;
    logic [SUM_W-1:0] c_sum;
    logic             c_wrap;
    logic [SUM_W-1:0] r_sum;
    logic             r_wrap;
    logic [POS_W-1:0] pos_sum;

    logic             mem_we;
    logic             mem_re;
    logic [PIX_W-1:0] mem_rdata;

    logic [POS_W-1:0] div_dvd;
    logic [DIM_W-1:0] div_dsr;
    logic             div_done;
    logic [POS_W-1:0] div_q;
    logic [DIM_W-1:0] div_r;

    always_comb
    begin
        unique case (op_reg)
            OP_COL:
            begin
                div_dvd = POS_W'(col_reg * sw_reg);
                div_dsr = dw_reg;
            end
            OP_ROW:
            begin
                div_dvd = POS_W'(row_reg * sh_reg);
                div_dsr = dh_reg;
            end
            OP_CSTEP:
            begin
                div_dvd = POS_W'(sw_reg);
                div_dsr = dw_reg;
            end
            OP_RSTEP:
            begin
                div_dvd = POS_W'(sh_reg);
                div_dsr = dh_reg;
            end
            default:
            begin
                div_dvd = '0;
                div_dsr = dw_reg;
            end
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == S_IDLE) && !settle_reg;
        in_acc   = in_ch.valid && in_ready;

        // zero counts as one, oversize counts as MAX_DIM
        cfg_val = 32'(cfg_data);
        if (cfg_val == 32'd0)
            cfg_dim = DIM_W'(1);
        else if (cfg_val > 32'(MAX_DIM))
            cfg_dim = DIM_W'(MAX_DIM);
        else
            cfg_dim = DIM_W'(cfg_val);

        wp_eff      = (wp_reg >= total_reg) ? '0 : wp_reg;
        wp_inc      = wp_eff + POS_W'(1);
        wp_in_store = 33'(wp_eff) < 33'(MAX_PIXELS);

        row_t    = SUM_W'(row_reg);
        col_last = SUM_W'(col_reg) == SUM_W'(dw_reg) - SUM_W'(1);
        row_last = SUM_W'(row_reg) == SUM_W'(dh_reg) - SUM_W'(1);
        c_sum    = SUM_W'(cr_reg) + SUM_W'(csr_reg);
        c_wrap   = c_sum >= SUM_W'(dw_reg);
        r_sum    = SUM_W'(rr_reg) + SUM_W'(rsr_reg);
        r_wrap   = r_sum >= SUM_W'(dh_reg);
        pos_sum  = POS_W'(rq_reg * sw_reg) + POS_W'(cq_reg);

        state_next     = state_reg;
        op_next        = op_reg;
        sw_next        = sw_reg;
        sh_next        = sh_reg;
        dw_next        = dw_reg;
        dh_next        = dh_reg;
        total_next     = POS_W'(sw_reg * sh_reg);
        settle_next    = cfg_we;
        geom_ok_next   = geom_ok_reg;
        wp_next        = wp_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        cq_next        = cq_reg;
        cr_next        = cr_reg;
        rq_next        = rq_reg;
        rr_next        = rr_reg;
        csq_next       = csq_reg;
        csr_next       = csr_reg;
        rsq_next       = rsq_reg;
        rsr_next       = rsr_reg;
        div_start_next = 1'b0;
        pos_next       = pos_reg;
        pend_in_next   = pend_in_reg;
        pend_x_next    = pend_x_reg;
        pend_y_next    = pend_y_reg;
        pend_last_next = pend_last_reg;
        out_valid_next = out_valid_reg;
        out_pix_next   = out_pix_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (cfg_we)
        begin
            geom_ok_next = 1'b0;
            unique case (cfg_idx_t'(cfg_index))
                REG_SRC_WIDTH:  sw_next = cfg_dim;
                REG_SRC_HEIGHT: sh_next = cfg_dim;
                REG_DST_WIDTH:  dw_next = cfg_dim;
                REG_DST_HEIGHT: dh_next = cfg_dim;
                default:        ;
            endcase
        end

        if (in_acc && (in_ch.cmd == CMD_LOAD))
        begin
            mem_we  = wp_in_store;
            wp_next = (wp_inc >= total_reg) ? '0 : wp_inc;
        end

        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (in_ch.cmd == CMD_EMIT))
                    state_next = geom_ok_reg ? S_EMIT : S_NORM;
            end
            S_NORM:
            begin
                // position may lie outside a frame that was made smaller
                if (SUM_W'(col_reg) >= SUM_W'(dw_reg))
                begin
                    col_next = '0;
                    row_t    = SUM_W'(row_reg) + SUM_W'(1);
                end
                if (row_t >= SUM_W'(dh_reg))
                    row_t = '0;
                row_next       = CRD_W'(row_t);
                op_next        = OP_COL;
                div_start_next = 1'b1;
                state_next     = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    unique case (op_reg)
                        OP_COL:
                        begin
                            cq_next        = CRD_W'(div_q);
                            cr_next        = div_r;
                            op_next        = OP_ROW;
                            div_start_next = 1'b1;
                        end
                        OP_ROW:
                        begin
                            rq_next        = CRD_W'(div_q);
                            rr_next        = div_r;
                            op_next        = OP_CSTEP;
                            div_start_next = 1'b1;
                        end
                        OP_CSTEP:
                        begin
                            csq_next       = DIM_W'(div_q);
                            csr_next       = div_r;
                            op_next        = OP_RSTEP;
                            div_start_next = 1'b1;
                        end
                        OP_RSTEP:
                        begin
                            rsq_next     = DIM_W'(div_q);
                            rsr_next     = div_r;
                            geom_ok_next = 1'b1;
                            state_next   = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                pos_next       = pos_sum;
                pend_in_next   = 33'(pos_sum) < 33'(MAX_PIXELS);
                pend_x_next    = OUT_CRD_W'(col_reg);
                pend_y_next    = OUT_CRD_W'(row_reg);
                pend_last_next = col_last && row_last;

                if (col_last)
                begin
                    col_next = '0;
                    cq_next  = '0;
                    cr_next  = '0;
                    if (row_last)
                    begin
                        row_next = '0;
                        rq_next  = '0;
                        rr_next  = '0;
                    end
                    else
                    begin
                        row_next = row_reg + CRD_W'(1);
                        rr_next  = r_wrap ? DIM_W'(r_sum - SUM_W'(dh_reg)) : DIM_W'(r_sum);
                        rq_next  = CRD_W'(SUM_W'(rq_reg) + SUM_W'(rsq_reg) + SUM_W'(r_wrap));
                    end
                end
                else
                begin
                    col_next = col_reg + CRD_W'(1);
                    cr_next  = c_wrap ? DIM_W'(c_sum - SUM_W'(dw_reg)) : DIM_W'(c_sum);
                    cq_next  = CRD_W'(SUM_W'(cq_reg) + SUM_W'(csq_reg) + SUM_W'(c_wrap));
                end
                state_next = S_RD;
            end
            S_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_DATA;
            end
            S_DATA:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = pend_in_reg ? mem_rdata : '0;
                    out_x_next     = pend_x_reg;
                    out_y_next     = pend_y_reg;
                    out_last_next  = pend_last_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_COL;
            sw_reg        <= DIM_W'(RST_SW);
            sh_reg        <= DIM_W'(RST_SH);
            dw_reg        <= DIM_W'(RST_DW);
            dh_reg        <= DIM_W'(RST_DH);
            total_reg     <= POS_W'(RST_SW * RST_SH);
            settle_reg    <= 1'b0;
            geom_ok_reg   <= 1'b0;
            wp_reg        <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            cq_reg        <= '0;
            cr_reg        <= '0;
            rq_reg        <= '0;
            rr_reg        <= '0;
            csq_reg       <= '0;
            csr_reg       <= '0;
            rsq_reg       <= '0;
            rsr_reg       <= '0;
            div_start_reg <= 1'b0;
            pos_reg       <= '0;
            pend_in_reg   <= 1'b0;
            pend_x_reg    <= '0;
            pend_y_reg    <= '0;
            pend_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pix_reg   <= '0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            sw_reg        <= sw_next;
            sh_reg        <= sh_next;
            dw_reg        <= dw_next;
            dh_reg        <= dh_next;
            total_reg     <= total_next;
            settle_reg    <= settle_next;
            geom_ok_reg   <= geom_ok_next;
            wp_reg        <= wp_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            cq_reg        <= cq_next;
            cr_reg        <= cr_next;
            rq_reg        <= rq_next;
            rr_reg        <= rr_next;
            csq_reg       <= csq_next;
            csr_reg       <= csr_next;
            rsq_reg       <= rsq_next;
            rsr_reg       <= rsr_next;
            div_start_reg <= div_start_next;
            pos_reg       <= pos_next;
            pend_in_reg   <= pend_in_next;
            pend_x_reg    <= pend_x_next;
            pend_y_reg    <= pend_y_next;
            pend_last_reg <= pend_last_next;
            out_valid_reg <= out_valid_next;
            out_pix_reg   <= out_pix_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_last_reg  <= out_last_next;
        end
    end

    nnis_div #(
        .DVD_W (POS_W),
        .DSR_W (DIM_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    nnis_store #(
        .DEPTH  (MAX_PIXELS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ADDR_W'(wp_eff)),
        .wdata (in_ch.pixel_in),
        .re    (mem_re),
        .raddr (ADDR_W'(pos_reg)),
        .rdata (mem_rdata)
    );

    assign in_ch.ready          = in_ready;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.pixel_out     = out_pix_reg;
    assign out_ch.dest_x        = out_x_reg;
    assign out_ch.dest_y        = out_y_reg;
    assign out_ch.last_of_frame = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/nnis_div.sv -----
// ----------------------------------------------------------------------------
// nnis_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_div #(
    parameter int DVD_W = 22,
    parameter int DSR_W = 11
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DSR_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient,
    output logic      [DSR_W-1:0] remainder
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quot_reg, quot_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, quot_reg[DVD_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = trial >= {1'b0, dsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // dividend bits shift out at the top, quotient bits shift in below
            quot_next = {quot_reg[DVD_W-2:0], ge};
            rem_next  = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            dsr_reg  <= dsr_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/nnis_store.sv -----
// ----------------------------------------------------------------------------
// nnis_store
// Source frame store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_store #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [ADDR_W-1:0]         waddr,
    input  wire logic [nnis_pkg::PIX_W-1:0] wdata,
    input  wire logic                      re,
    input  wire logic [ADDR_W-1:0]         raddr,
    output logic      [nnis_pkg::PIX_W-1:0] rdata
);
    import nnis_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/nnis_checker.sv -----
// ----------------------------------------------------------------------------
// nnis_checker
// Port-level checks on the scaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nnis_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           in_cmd,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [nnis_pkg::PIX_W-1:0]     out_pixel,
    input wire logic [nnis_pkg::OUT_CRD_W-1:0] out_x,
    input wire logic [nnis_pkg::OUT_CRD_W-1:0] out_y,
    input wire logic                           out_last,
    input wire logic                           cfg_we
);
    import nnis_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(out_x)
            && $stable(out_y) && $stable(out_last))
        else $error("result changed or dropped while stalled");

    // register write holds off requests while the derived totals settle
    a_cfg_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("request taken right after a register write");

    // an emit request occupies the block past its accept cycle
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_cmd == CMD_EMIT) |=> !in_ready)
        else $error("request taken while an emit is in flight");

    // a new result only leaves the output stage, never the idle state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without an emit in flight");

endmodule

bind nearest_neighbor_image_scaler nnis_checker u_nnis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_cmd    (in_ch.cmd),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_pixel (out_ch.pixel_out),
    .out_x     (out_ch.dest_x),
    .out_y     (out_ch.dest_y),
    .out_last  (out_ch.last_of_frame),
    .cfg_we    (cfg_we)
);

`default_nettype wire
